>>> rtl/core/nmeac_pkg.sv
// nmeac_pkg: shared constants, types and a helper function of the sentence checker
// no dependencies; imported by nmeac_finish and nmea_sentence_checker_core
`default_nettype none

package nmeac_pkg;

	// longest line kept before the line state is dropped
	localparam int MAX_LINE = 600;
	localparam int LINE_W = $clog2(MAX_LINE + 1);

	localparam int BYTE_W = 8;
	localparam int PAYLOAD_W = 10;
	localparam int COUNT_W = 32;
	localparam int TYPE_W = 4;

	// shortest line that is checked at all is one longer than this
	localparam int MIN_LINE = 6;

	// number of leading characters kept for the prefix match
	localparam int PREFIX_MAX = 8;
	localparam int PREFIX_IDX_W = $clog2(PREFIX_MAX);
	localparam int PREFIX_LEN_W = $clog2(PREFIX_MAX + 1);
	localparam int NUM_TYPES = 12;

	localparam logic [BYTE_W-1:0] CHAR_FIRST = 8'd32;
	localparam logic [BYTE_W-1:0] CHAR_LAST = 8'd126;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = "$";
	localparam logic [BYTE_W-1:0] CHAR_STAR = "*";

	typedef enum logic [1:0] {
		CK_MATCH    = 2'd0,
		CK_MISMATCH = 2'd1,
		CK_NONHEX   = 2'd2,
		CK_ABSENT   = 2'd3
	} ck_status_t;

	// sentence prefixes in match priority order, zero padded
	localparam logic [BYTE_W-1:0] PREFIX_CHARS [NUM_TYPES][PREFIX_MAX] = '{
		'{"$", "G", "N", "G", "G", "A", 8'h00, 8'h00},
		'{"$", "G", "P", "G", "G", "A", 8'h00, 8'h00},
		'{"$", "G", "N", "R", "M", "C", 8'h00, 8'h00},
		'{"$", "G", "P", "R", "M", "C", 8'h00, 8'h00},
		'{"$", "G", "P", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "G", "N", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "G", "L", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "G", "A", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "G", "B", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "G", "Q", "G", "S", "V", 8'h00, 8'h00},
		'{"$", "P", "Q", "T", "M", "E", "P", "E"},
		'{"$", "P", "Q", "T", "M", "P", "L", 8'h00}
	};

	localparam logic [PREFIX_LEN_W-1:0] PREFIX_LEN [NUM_TYPES] = '{
		PREFIX_LEN_W'(6), PREFIX_LEN_W'(6), PREFIX_LEN_W'(6), PREFIX_LEN_W'(6),
		PREFIX_LEN_W'(6), PREFIX_LEN_W'(6), PREFIX_LEN_W'(6), PREFIX_LEN_W'(6),
		PREFIX_LEN_W'(6), PREFIX_LEN_W'(6), PREFIX_LEN_W'(8), PREFIX_LEN_W'(7)
	};

	// per-line state, cleared at end of line and on overflow
	typedef struct packed {
		logic [LINE_W-1:0]                  len;
		logic                               dollar;
		logic [PREFIX_MAX-1:0][BYTE_W-1:0]  prefix;
		logic [BYTE_W-1:0]                  run_xor;
		logic [BYTE_W-1:0]                  star_xor;
		logic [LINE_W-1:0]                  star_pos;
		logic [2*BYTE_W-1:0]                digits;
		logic [1:0]                         digit_cnt;
	} line_state_t;

	// verdict on the current line if it were ended now
	typedef struct packed {
		logic                  hit;
		logic [TYPE_W-1:0]     stype;
		ck_status_t            status;
		logic [PAYLOAD_W-1:0]  length;
		logic                  count_err;
	} finish_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] ch);
		hex_t r;
		r.ok = 1'b1;
		r.value = 4'd0;
		if (ch >= "0" && ch <= "9") begin
			r.value = 4'(ch - "0");
		end else if (ch >= "A" && ch <= "F") begin
			r.value = 4'(ch - "A" + 8'd10);
		end else if (ch >= "a" && ch <= "f") begin
			r.value = 4'(ch - "a" + 8'd10);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/nmeac_finish.sv
// nmeac_finish: end-of-line verdict (prefix match and checksum compare)
// depends on nmeac_pkg; purely combinational, fed from the line state register
`default_nettype none

module nmeac_finish
	import nmeac_pkg::*;
(
	input  line_state_t line,
	output finish_t     verdict
);

	logic                          has_ck;
	logic [LINE_W-1:0]             limit;
	logic [LINE_W+PAYLOAD_W-1:0]   limit_wide;
	logic                          found;
	logic [TYPE_W-1:0]             found_type;
	logic                          same;
	hex_t                          hi;
	hex_t                          lo;
	ck_status_t                    status;

	assign has_ck = (line.star_pos != '0) && (line.digit_cnt == 2'd2);
	assign limit = has_ck ? line.star_pos : line.len;
	assign limit_wide = {{PAYLOAD_W{1'b0}}, limit};

	// first matching prefix wins: scan backwards so the lowest index lands last
	always_comb begin
		found = 1'b0;
		found_type = '0;
		same = 1'b0;
		for (int k = NUM_TYPES - 1; k >= 0; k--) begin
			same = (limit >= LINE_W'(PREFIX_LEN[k]));
			for (int i = 0; i < PREFIX_MAX; i++) begin
				if (PREFIX_LEN_W'(i) < PREFIX_LEN[k] && line.prefix[i] != PREFIX_CHARS[k][i]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				found = 1'b1;
				found_type = TYPE_W'(k);
			end
		end
	end

	assign hi = hex_decode(line.digits[2*BYTE_W-1:BYTE_W]);
	assign lo = hex_decode(line.digits[BYTE_W-1:0]);

	always_comb begin
		if (!has_ck) begin
			status = CK_ABSENT;
		end else if (!hi.ok || !lo.ok) begin
			status = CK_NONHEX;
		end else if ({hi.value, lo.value} == line.star_xor) begin
			status = CK_MATCH;
		end else begin
			status = CK_MISMATCH;
		end
	end

	always_comb begin
		verdict.hit = found && line.dollar && (line.len > LINE_W'(MIN_LINE));
		verdict.stype = found_type;
		verdict.status = status;
		verdict.length = limit_wide[PAYLOAD_W-1:0];
		verdict.count_err = verdict.hit && (status == CK_MISMATCH || status == CK_NONHEX);
	end

endmodule

`default_nettype wire

>>> rtl/core/nmea_sentence_checker_core.sv
// nmea_sentence_checker_core: top level of the nmea 0183 sentence checker
// depends on nmeac_pkg and nmeac_finish
`default_nettype none

// One received byte enters per item on the rx_byte channel. Printable bytes (32..126) extend
// the current line, CR or LF end it, all other bytes are ignored; a line that grows past
// MAX_LINE characters is thrown away. At the end of a line longer than six characters that
// starts with '$' and begins with one of the twelve known sentence prefixes, one result item
// comes out: the sentence type, the checksum status, the payload length (index of the last
// '*' when a two-digit checksum follows it, else the whole line length) and the running count
// of bad checksums. Sentences with a bad checksum are still reported; they only bump the
// wrapping error counter. Lines that do not qualify produce nothing. The block takes one byte
// per cycle except while stalled: each byte is held in an input register, and the line update,
// prefix match and checksum compare are all combinational on it, so a result is loaded into the
// output register as its CR/LF byte leaves the input register. A result waiting in the output
// register stalls the input register only when the consumer holds out_ready low.
module nmea_sentence_checker_core
	import nmeac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [BYTE_W-1:0]     rx_byte,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [TYPE_W-1:0]     sentence_type,
	output      logic [1:0]            checksum_status,
	output      logic [PAYLOAD_W-1:0]  payload_length,
	output      logic [COUNT_W-1:0]    checksum_errors
);

	// input register
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	// line state and error counter
	line_state_t         line_q;
	line_state_t         line_next;
	logic [COUNT_W-1:0]  errors_q;
	logic [COUNT_W-1:0]  errors_next;

	// output register
	logic                out_valid_q;
	logic [TYPE_W-1:0]   type_q;
	ck_status_t          status_q;
	logic [PAYLOAD_W-1:0] length_q;
	logic [COUNT_W-1:0]  count_q;

	finish_t             verdict;
	logic                out_free;
	logic                advance;
	logic                printable;
	logic                eol;
	logic                emit;

	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign advance = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign printable = (byte_s1 >= CHAR_FIRST) && (byte_s1 <= CHAR_LAST);
	assign eol = (byte_s1 == CHAR_CR) || (byte_s1 == CHAR_LF);
	assign emit = advance && eol && verdict.hit;

	// verdict is formed on the line as it stood before the terminating byte
	nmeac_finish u_finish (
		.line    (line_q),
		.verdict (verdict)
	);

	// one byte of line update
	always_comb begin
		line_next = line_q;
		if (printable) begin
			if (line_q.len == '0) begin
				line_next.dollar = (byte_s1 == CHAR_DOLLAR);
			end
			if (line_q.len < LINE_W'(PREFIX_MAX)) begin
				line_next.prefix[line_q.len[PREFIX_IDX_W-1:0]] = byte_s1;
			end
			// a star in the first position is not a checksum marker
			if (line_q.len != '0) begin
				if (byte_s1 == CHAR_STAR) begin
					line_next.star_xor = line_q.run_xor;
					line_next.star_pos = line_q.len;
					line_next.digits = '0;
					line_next.digit_cnt = 2'd0;
				end else if (line_q.star_pos != '0 && line_q.digit_cnt != 2'd2) begin
					if (line_q.digit_cnt == 2'd0) begin
						line_next.digits[2*BYTE_W-1:BYTE_W] = byte_s1;
					end else begin
						line_next.digits[BYTE_W-1:0] = byte_s1;
					end
					line_next.digit_cnt = line_q.digit_cnt + 2'd1;
				end
				line_next.run_xor = line_q.run_xor ^ byte_s1;
			end
			line_next.len = line_q.len + LINE_W'(1);
			// overlong line: drop everything gathered so far
			if (line_q.len == LINE_W'(MAX_LINE)) begin
				line_next = '0;
			end
		end else if (eol) begin
			line_next = '0;
		end
	end

	assign errors_next = errors_q + COUNT_W'(verdict.count_err && eol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			errors_q <= '0;
		end else if (advance) begin
			line_q <= line_next;
			errors_q <= errors_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			type_q <= verdict.stype;
			status_q <= verdict.status;
			length_q <= verdict.length;
			count_q <= errors_next;
		end
	end

	assign out_valid = out_valid_q;
	assign sentence_type = type_q;
	assign checksum_status = status_q;
	assign payload_length = length_q;
	assign checksum_errors = count_q;

	// a bad checksum on a reported sentence adds exactly one to the counter
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit && verdict.count_err |=> errors_q == $past(errors_q) + COUNT_W'(1))
		else $error("error counter did not advance on a bad checksum");

	// the counter moves only when a result is produced
	a_err_only_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> errors_q == $past(errors_q))
		else $error("error counter changed without a result");

	// the kept line never exceeds its limit
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.len <= LINE_W'(MAX_LINE))
		else $error("line length past limit");

	// a reported sentence always covers at least a full short prefix
	a_length_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> length_q >= PAYLOAD_W'(MIN_LINE))
		else $error("reported payload shorter than any prefix");

endmodule

`default_nettype wire
